FILE: rtl/core/sle_pkg.sv
package sle_pkg;

	localparam int CAPACITY = 64;
	localparam int AW       = $clog2(CAPACITY);
	localparam int CW       = 7;
	localparam int DW       = 32;

	localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);

	typedef enum logic [2:0] {
		MODE_CLEAR  = 3'd0,
		MODE_GET    = 3'd1,
		MODE_LOCATE = 3'd2,
		MODE_PRED   = 3'd3,
		MODE_SUCC   = 3'd4,
		MODE_INSERT = 3'd5,
		MODE_DELETE = 3'd6,
		MODE_NOP    = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_RANGE    = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_NONEIGH  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_GETW,
		S_SCAN,
		S_SUCCW,
		S_INS,
		S_DEL
	} state_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [DW-1:0] wdata;
		logic [AW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		status_t       status;
		logic [DW-1:0] value;
		logic [CW-1:0] fpos;
		logic [CW-1:0] len;
		logic          empty;
	} result_t;

endpackage

FILE: rtl/core/sequential_list_engine.sv
// Clear, no-op, a bad position and a full list finish in the dispatch state; get adds one store
// read. Locate, predecessor and successor scan the list from the front and stop at the first match.
// Insert shifts the words from the position to the end up by one (none when appending), delete down.
// One word at a time: the next start is taken at the edge that ends done.
// Reset clears the length and the sequencer; the store contents are not cleared.
// done pulses for one cycle with the result; the receiver cannot stall it.
module sequential_list_engine
	import sle_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [2:0]           mode,
	input  logic [CW-1:0]        position,
	input  logic signed [DW-1:0] value,
	output logic                 busy,
	output logic                 done,
	output logic [2:0]           status,
	output logic signed [DW-1:0] value_out,
	output logic [CW-1:0]        found_position,
	output logic [CW-1:0]        list_length,
	output logic                 is_empty
);

	mem_req_t      mem_req;
	logic [DW-1:0] rdata;
	logic          res_fire;
	result_t       res;
	logic          done_q;
	result_t       res_q;

	sle_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	sle_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.mode     (mode),
		.position (position),
		.value    (value),
		.busy     (busy),
		.mem_req  (mem_req),
		.rdata    (rdata),
		.res_fire (res_fire),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			res_q <= res;
		end
	end

	assign done           = done_q;
	assign status         = res_q.status;
	assign value_out      = res_q.value;
	assign found_position = res_q.fpos;
	assign list_length    = res_q.len;
	assign is_empty       = res_q.empty;

endmodule

FILE: rtl/core/sle_ram.sv
module sle_ram
	import sle_pkg::*;
(
	input  logic          clk,
	input  mem_req_t      req,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [CAPACITY];
	logic [DW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_q <= mem_q[req.raddr];
	end

	assign rdata = rd_q;

endmodule

FILE: rtl/core/sle_seq.sv
module sle_seq
	import sle_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [2:0]    mode,
	input  logic [CW-1:0] position,
	input  logic [DW-1:0] value,
	output logic          busy,
	output mem_req_t      mem_req,
	input  logic [DW-1:0] rdata,
	output logic          res_fire,
	output result_t       res
);

	state_t        state_q, state_d;
	mode_t         mode_q, mode_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [DW-1:0] val_q, val_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [DW-1:0] prev_q, prev_d;
	logic [DW-1:0] vout_q, vout_d;
	logic          pend_s1, pend_d;
	logic [CW-1:0] tag_s1, tag_d;

	logic [CW-1:0] pos_m1;
	logic [CW-1:0] tag_m1;
	logic [CW-1:0] tag_p1;
	logic          pos_ok_rd;
	logic          pos_ok_ins;
	logic          issue;

	assign pos_m1     = pos_q - 7'd1;
	assign tag_m1     = tag_s1 - 7'd1;
	assign tag_p1     = tag_s1 + 7'd1;
	assign pos_ok_rd  = (pos_q != '0) && (pos_q <= cnt_q);
	assign pos_ok_ins = (pos_q != '0) && (pos_q <= cnt_q + 7'd1);
	assign busy       = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_s1 <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q <= mode_d;
		pos_q  <= pos_d;
		val_q  <= val_d;
		idx_q  <= idx_d;
		prev_q <= prev_d;
		vout_q <= vout_d;
		tag_s1 <= tag_d;
	end

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		pos_d      = pos_q;
		val_d      = val_q;
		cnt_d      = cnt_q;
		idx_d      = idx_q;
		prev_d     = prev_q;
		vout_d     = vout_q;
		pend_d     = 1'b0;
		tag_d      = tag_s1;
		issue      = 1'b0;
		mem_req    = '{we: 1'b0, waddr: '0, wdata: '0, raddr: idx_q[AW-1:0]};
		res_fire   = 1'b0;
		res.status = ST_OK;
		res.value  = '0;
		res.fpos   = '0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					mode_d  = mode_t'(mode);
					pos_d   = position;
					val_d   = value;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (mode_q) inside
					MODE_CLEAR: begin
						cnt_d    = '0;
						res_fire = 1'b1;
					end
					MODE_GET: begin
						if (!pos_ok_rd) begin
							res.status = ST_RANGE;
							res_fire   = 1'b1;
						end else begin
							mem_req.raddr = pos_m1[AW-1:0];
							state_d       = S_GETW;
						end
					end
					MODE_LOCATE, MODE_PRED, MODE_SUCC: begin
						idx_d   = '0;
						state_d = S_SCAN;
					end
					MODE_INSERT: begin
						if (!pos_ok_ins) begin
							res.status = ST_RANGE;
							res_fire   = 1'b1;
						end else if (cnt_q >= CNT_CAP) begin
							res.status = ST_FULL;
							res_fire   = 1'b1;
						end else begin
							idx_d   = cnt_q;
							state_d = S_INS;
						end
					end
					MODE_DELETE: begin
						if (!pos_ok_rd) begin
							res.status = ST_RANGE;
							res_fire   = 1'b1;
						end else begin
							idx_d   = pos_m1;
							state_d = S_DEL;
						end
					end
					default: begin
						res_fire = 1'b1;
					end
				endcase
			end
			S_GETW: begin
				res.value = rdata;
				res_fire  = 1'b1;
			end
			S_SCAN: begin
				issue = (idx_q < cnt_q);
				if (issue) begin
					mem_req.raddr = idx_q[AW-1:0];
					idx_d         = idx_q + 7'd1;
					tag_d         = idx_q;
					pend_d        = 1'b1;
				end
				if (pend_s1) begin
					if (rdata == val_q) begin
						case (mode_q)
							MODE_LOCATE: begin
								res.fpos = tag_p1;
								res_fire = 1'b1;
							end
							MODE_PRED: begin
								if (tag_s1 == '0) begin
									res.status = ST_NONEIGH;
								end else begin
									res.value = prev_q;
								end
								res_fire = 1'b1;
							end
							default: begin
								// successor read is already in flight
								if (tag_p1 >= cnt_q) begin
									res.status = ST_NONEIGH;
									res_fire   = 1'b1;
								end else begin
									state_d = S_SUCCW;
								end
							end
						endcase
					end else begin
						prev_d = rdata;
					end
				end else if (!issue) begin
					res.status = ST_NOTFOUND;
					res_fire   = 1'b1;
				end
			end
			S_SUCCW: begin
				res.value = rdata;
				res_fire  = 1'b1;
			end
			S_INS: begin
				if (pend_s1) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = tag_s1[AW-1:0];
					mem_req.wdata = rdata;
				end
				if (idx_q >= pos_q) begin
					mem_req.raddr = idx_d[AW-1:0];
					idx_d         = idx_q - 7'd1;
					mem_req.raddr = idx_d[AW-1:0];
					tag_d         = idx_q;
					pend_d        = 1'b1;
				end else if (!pend_s1) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = pos_m1[AW-1:0];
					mem_req.wdata = val_q;
					cnt_d         = cnt_q + 7'd1;
					res_fire      = 1'b1;
				end
			end
			S_DEL: begin
				issue = (idx_q < cnt_q);
				if (issue) begin
					mem_req.raddr = idx_q[AW-1:0];
					idx_d         = idx_q + 7'd1;
					tag_d         = idx_q;
					pend_d        = 1'b1;
				end
				if (pend_s1) begin
					if (tag_s1 == pos_m1) begin
						vout_d = rdata;
					end else begin
						mem_req.we    = 1'b1;
						mem_req.waddr = tag_m1[AW-1:0];
						mem_req.wdata = rdata;
					end
				end else if (!issue) begin
					cnt_d     = cnt_q - 7'd1;
					res.value = vout_q;
					res_fire  = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (res_fire) begin
			state_d = S_IDLE;
		end
		res.len   = cnt_d;
		res.empty = (cnt_d == '0);
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_CAP)
		else $error("length beyond capacity");

	a_fire_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |=> state_q == S_IDLE)
		else $error("sequencer not idle after result");

	a_write_ops: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> (state_q == S_INS || state_q == S_DEL))
		else $error("store written outside insert or delete");

	a_tag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && (state_q == S_SCAN || state_q == S_DEL)) |-> tag_s1 < cnt_q)
		else $error("read beyond list length");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |-> cnt_q < CNT_CAP)
		else $error("insert into full list");

endmodule
